@@ design/thct_pkg.sv @@
// ----------------------------------------------------------------------------
// thct_pkg
// Shared types, constants and register codes for the temperature-driven
// oscillator trim with three-band hysteresis.
// ----------------------------------------------------------------------------
package thct_pkg;

    localparam int AVG_COUNT = 3;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = $clog2(((1 << SAMPLE_W) - 1) * AVG_COUNT + 1);
    localparam int CNT_W     = $clog2(AVG_COUNT + 1);

    localparam int DIV_SHIFT = SUM_W + 3;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int RECIP     = ((1 << DIV_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam int GRAD_W     = 16;
    localparam int GRAD_RECIP = 10452;
    localparam int FRAC_W     = 16;
    localparam int ROUND_BIAS = (1 << FRAC_W) - 1;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int TPROD_W    = DIFF_W + GRAD_W;
    localparam int TEMP_W     = 12;
    localparam int TEMP_OUT_W = 11;

    localparam int TUNE_W    = 8;
    localparam int THR_W     = 8;
    localparam int TRIM_STEP = 10;
    localparam int TUNE_MAX  = (1 << TUNE_W) - 1;

    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQPTR_W  = $clog2(OQ_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TUNING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_ENTER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_EXIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_ENTER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_EXIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_ADC     = 3'd6;

    localparam logic [1:0] BAND_NORMAL = 2'd0;
    localparam logic [1:0] BAND_HOT    = 2'd1;
    localparam logic [1:0] BAND_COLD   = 2'd2;

    typedef struct packed {
        logic [TUNE_W-1:0]        base_tuning;
        logic signed [THR_W-1:0]  hot_enter;
        logic signed [THR_W-1:0]  hot_exit;
        logic signed [THR_W-1:0]  cold_enter;
        logic signed [THR_W-1:0]  cold_exit;
        logic [TUNE_W-1:0]        cal_temp;
        logic [SAMPLE_W-1:0]      cal_adc;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temperature;
        logic [1:0]                   band;
        logic [TUNE_W-1:0]            tuning_word;
        logic                         band_changed;
    } result_t;

endpackage

@@ design/thct_cfg.sv @@
// ----------------------------------------------------------------------------
// thct_cfg
// Configuration register file; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module thct_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [thct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [thct_pkg::CFG_DATA_W-1:0]    cfg_data,
    output thct_pkg::cfg_t                     cfg
);
    import thct_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BASE_TUNING: cfg_next.base_tuning = cfg_data[TUNE_W-1:0];
                REG_HOT_ENTER:   cfg_next.hot_enter   = $signed(cfg_data[THR_W-1:0]);
                REG_HOT_EXIT:    cfg_next.hot_exit    = $signed(cfg_data[THR_W-1:0]);
                REG_COLD_ENTER:  cfg_next.cold_enter  = $signed(cfg_data[THR_W-1:0]);
                REG_COLD_EXIT:   cfg_next.cold_exit   = $signed(cfg_data[THR_W-1:0]);
                REG_CAL_TEMP:    cfg_next.cal_temp    = cfg_data[TUNE_W-1:0];
                REG_CAL_ADC:     cfg_next.cal_adc     = cfg_data[SAMPLE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_tuning <= 8'd128;
            cfg_reg.hot_enter   <= 8'sd40;
            cfg_reg.hot_exit    <= 8'sd35;
            cfg_reg.cold_enter  <= 8'sd0;
            cfg_reg.cold_exit   <= 8'sd5;
            cfg_reg.cal_temp    <= 8'd25;
            cfg_reg.cal_adc     <= 12'd2048;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/thct_front.sv @@
// ----------------------------------------------------------------------------
// thct_front
// Sample accumulator: sums samples in groups and hands each finished group
// sum to the queue.
// ----------------------------------------------------------------------------
module thct_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [thct_pkg::SAMPLE_W-1:0]    sensor_sample,
    input  logic                             q_full,
    output logic                             q_push,
    output logic [thct_pkg::SUM_W-1:0]       q_data
);
    import thct_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             last;
    logic [SUM_W-1:0] total;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign last   = (count_reg == CNT_W'(AVG_COUNT - 1));
    assign total  = sum_reg + SUM_W'(sensor_sample);
    assign q_push = accept && last;
    assign q_data = total;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = total;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ design/thct_queue.sv @@
// ----------------------------------------------------------------------------
// thct_queue
// Short queue of group sums between the accumulator and the arithmetic
// pipeline.
// ----------------------------------------------------------------------------
module thct_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_push,
    input  logic [thct_pkg::SUM_W-1:0]   q_data,
    output logic                         q_full,
    input  logic                         q_pop,
    output logic [thct_pkg::SUM_W-1:0]   q_head,
    output logic                         q_empty
);
    import thct_pkg::*;

    logic [SUM_W-1:0]  mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == (QPTR_W + 1)'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ design/thct_back.sv @@
// ----------------------------------------------------------------------------
// thct_back
// Arithmetic pipeline: group average, temperature conversion, hysteresis
// band machine and result queue.
// ----------------------------------------------------------------------------
module thct_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  thct_pkg::cfg_t                      cfg,
    input  logic [thct_pkg::SUM_W-1:0]          q_head,
    input  logic                                q_empty,
    output logic                                q_pop,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [thct_pkg::TEMP_OUT_W-1:0] temperature,
    output logic [1:0]                          band,
    output logic [thct_pkg::TUNE_W-1:0]         tuning_word,
    output logic                                band_changed
);
    import thct_pkg::*;

    // Pipeline advances whenever the result queue has room.
    logic advance;

    logic                       v1_reg;
    logic [PROD_W-1:0]          prod1_reg;
    logic                       v2_reg;
    logic signed [TPROD_W-1:0]  tprod2_reg;
    logic                       v3_reg;
    logic signed [TEMP_W-1:0]   temp3_reg;

    logic [SAMPLE_W-1:0]        avg;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [TPROD_W-1:0]  tprod;
    logic signed [TPROD_W-1:0]  biased;
    logic signed [TPROD_W-1:0]  shifted;
    logic signed [TEMP_W-1:0]   temp;

    logic [1:0]                 band_reg;
    logic [1:0]                 band_next;
    logic signed [TEMP_W-1:0]   hot_enter_x;
    logic signed [TEMP_W-1:0]   hot_exit_x;
    logic signed [TEMP_W-1:0]   cold_enter_x;
    logic signed [TEMP_W-1:0]   cold_exit_x;
    logic [TUNE_W-1:0]          tune;
    result_t                    result;

    result_t                    oq_reg [OQ_DEPTH];
    logic [OQPTR_W-1:0]         oq_wr_reg;
    logic [OQPTR_W-1:0]         oq_rd_reg;
    logic [OQPTR_W:0]           oq_count_reg;
    logic [OQPTR_W:0]           oq_count_next;
    logic                       oq_full;
    logic                       oq_write;
    logic                       oq_read;

    assign oq_full  = (oq_count_reg == (OQPTR_W + 1)'(OQ_DEPTH));
    assign empty    = (oq_count_reg == '0);
    assign advance  = !oq_full;
    assign q_pop    = advance && !q_empty;
    assign oq_write = advance && v3_reg;
    assign oq_read  = pop && !empty;

    assign avg   = prod1_reg[DIV_SHIFT +: SAMPLE_W];
    assign diff  = $signed({1'b0, cfg.cal_adc}) - $signed({1'b0, avg});
    assign tprod = diff * $signed(GRAD_W'(GRAD_RECIP));

    // Arithmetic shift rounds down, so negative values get a bias first.
    assign biased  = tprod2_reg + (tprod2_reg[TPROD_W-1]
                     ? $signed(TPROD_W'(ROUND_BIAS)) : $signed(TPROD_W'(0)));
    assign shifted = biased >>> FRAC_W;
    assign temp    = $signed({{(TEMP_W - TUNE_W){1'b0}}, cfg.cal_temp})
                     + shifted[TEMP_W-1:0];

    assign hot_enter_x  = TEMP_W'(cfg.hot_enter);
    assign hot_exit_x   = TEMP_W'(cfg.hot_exit);
    assign cold_enter_x = TEMP_W'(cfg.cold_enter);
    assign cold_exit_x  = TEMP_W'(cfg.cold_exit);

    always_comb
    begin
        band_next = band_reg;
        unique case (band_reg)
            BAND_NORMAL:
            begin
                if (temp3_reg < cold_enter_x)
                begin
                    band_next = BAND_COLD;
                end
                else if (temp3_reg > hot_enter_x)
                begin
                    band_next = BAND_HOT;
                end
            end
            BAND_HOT:
            begin
                if (temp3_reg < hot_exit_x)
                begin
                    band_next = BAND_NORMAL;
                end
            end
            default:
            begin
                if (temp3_reg > cold_exit_x)
                begin
                    band_next = BAND_NORMAL;
                end
            end
        endcase
    end

    always_comb
    begin
        case (band_next)
            BAND_HOT:
            begin
                tune = (cfg.base_tuning < TUNE_W'(TRIM_STEP))
                       ? '0 : cfg.base_tuning - TUNE_W'(TRIM_STEP);
            end
            BAND_COLD:
            begin
                tune = (cfg.base_tuning > TUNE_W'(TUNE_MAX - TRIM_STEP))
                       ? TUNE_W'(TUNE_MAX) : cfg.base_tuning + TUNE_W'(TRIM_STEP);
            end
            default:
            begin
                tune = cfg.base_tuning;
            end
        endcase
    end

    assign result.temperature  = temp3_reg[TEMP_OUT_W-1:0];
    assign result.band         = band_next;
    assign result.tuning_word  = tune;
    assign result.band_changed = (band_next != band_reg);

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_write && !oq_read)
        begin
            oq_count_next = oq_count_reg + (OQPTR_W + 1)'(1);
        end
        else if (oq_read && !oq_write)
        begin
            oq_count_next = oq_count_reg - (OQPTR_W + 1)'(1);
        end
    end

    assign temperature  = oq_reg[oq_rd_reg].temperature;
    assign band         = oq_reg[oq_rd_reg].band;
    assign tuning_word  = oq_reg[oq_rd_reg].tuning_word;
    assign band_changed = oq_reg[oq_rd_reg].band_changed;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod1_reg  <= PROD_W'(q_head) * PROD_W'(RECIP);
            tprod2_reg <= tprod;
            temp3_reg  <= temp;
        end
        if (oq_write)
        begin
            oq_reg[oq_wr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            band_reg     <= BAND_NORMAL;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                v1_reg <= !q_empty;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            if (oq_write)
            begin
                band_reg  <= band_next;
                oq_wr_reg <= oq_wr_reg + OQPTR_W'(1);
            end
            if (oq_read)
            begin
                oq_rd_reg <= oq_rd_reg + OQPTR_W'(1);
            end
            oq_count_reg <= oq_count_next;
        end
    end

endmodule

@@ design/temp_hysteresis_clock_trim.sv @@
// ----------------------------------------------------------------------------
// temp_hysteresis_clock_trim
// Accepts one sample per cycle while the group queue is not full; every third
// sample completes a group. A group's sum is queued, then registered by the
// divide, convert and band pipeline stages and written into the result queue.
// One result per group, up to one per cycle, while the result queue drains.
// Reset is asynchronous: registers return to defaults, queues empty, band normal.
// ----------------------------------------------------------------------------
module temp_hysteresis_clock_trim (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [thct_pkg::SAMPLE_W-1:0]       sensor_sample,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [thct_pkg::TEMP_OUT_W-1:0] temperature,
    output logic [1:0]                          band,
    output logic [thct_pkg::TUNE_W-1:0]         tuning_word,
    output logic                                band_changed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [thct_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import thct_pkg::*;

    cfg_t             cfg;
    logic             q_push;
    logic [SUM_W-1:0] q_data;
    logic             q_full;
    logic             q_pop;
    logic [SUM_W-1:0] q_head;
    logic             q_empty;

    thct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thct_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sensor_sample (sensor_sample),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    thct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_data  (q_data),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    thct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .temperature  (temperature),
        .band         (band),
        .tuning_word  (tuning_word),
        .band_changed (band_changed)
    );

    // A finished group must never meet a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("group sum pushed into a full queue");

    // The pipeline only takes sums that are present.
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("pipeline popped an empty queue");

    // A pushed group leaves the queue non-empty on the next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_full |=> !q_empty)
        else $error("pushed group sum lost");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for temp_hysteresis_clock_trim. ADC samples are
// pushed through the input queue and each trim result is popped and compared,
// field by field, with a cycle-free prediction of group averaging, the
// fixed-point degree conversion and the three-band hysteresis. Directed
// groups hit the reset settings, every threshold at equality, both band
// entries at once and the conversion and tuning extremes. Random phases
// reprogram all registers; cluster phases drive slow temperature walks with
// noise, the others random samples. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import thct_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int GROUP_LEN    = 3;
    localparam int GRAD_Q16     = 10452;
    localparam int Q16_ONE      = 65536;
    localparam int TRIM_DELTA   = 10;
    localparam int QUIET_CYCLES = 16;
    localparam int STALL_LIMIT  = 500;
    localparam int RAND_PHASES  = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {SET_CLUSTER, SET_SCATTER, SET_FLOOR, SET_CEILING} setting_kind_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic [SAMPLE_W-1:0]          sensor_sample;
    logic                         pop;
    logic                         empty;
    logic signed [TEMP_OUT_W-1:0] temperature;
    logic [1:0]                   band;
    logic [TUNE_W-1:0]            tuning_word;
    logic                         band_changed;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;

    logic [TUNE_W-1:0]       trim_base;
    logic signed [THR_W-1:0] thr_hot_enter;
    logic signed [THR_W-1:0] thr_hot_exit;
    logic signed [THR_W-1:0] thr_cold_enter;
    logic signed [THR_W-1:0] thr_cold_exit;
    logic [TUNE_W-1:0]       calib_temp;
    logic [SAMPLE_W-1:0]     calib_adc;
    int                      grp_sum;
    int                      grp_cnt;
    logic [1:0]              band_st;

    result_t pending_trims[$];
    result_t want;

    int tx_gap_max   = 4;
    int rx_stall_max = 4;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int n_samples    = 0;
    int n_results    = 0;
    int n_changes    = 0;
    int n_writes     = 0;
    int n_settings   = 0;

    temp_hysteresis_clock_trim dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sensor_sample (sensor_sample),
        .pop           (pop),
        .empty         (empty),
        .temperature   (temperature),
        .band          (band),
        .tuning_word   (tuning_word),
        .band_changed  (band_changed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int degrees_from_avg(input int avg);
        int span;
        span = int'(calib_adc) - avg;
        return int'(calib_temp) + (span * GRAD_Q16) / Q16_ONE;
    endfunction

    function automatic int adc_for_degrees(input int deg);
        for (int a = 0; a < (1 << SAMPLE_W); a++)
        begin
            if (degrees_from_avg(a) == deg)
                return a;
        end
        return 0;
    endfunction

    function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s);
        int         deg;
        int         tune;
        logic [1:0] prev;
        result_t    r;
        grp_sum += int'(s);
        grp_cnt++;
        if (grp_cnt < GROUP_LEN)
            return;
        deg = degrees_from_avg(grp_sum / GROUP_LEN);
        grp_sum = 0;
        grp_cnt = 0;
        prev = band_st;
        case (band_st)
            BAND_NORMAL:
            begin
                if (deg > thr_hot_enter)
                    band_st = BAND_HOT;
                if (deg < thr_cold_enter)
                    band_st = BAND_COLD;
            end
            BAND_HOT:
            begin
                if (deg < thr_hot_exit)
                    band_st = BAND_NORMAL;
            end
            default:
            begin
                if (deg > thr_cold_exit)
                    band_st = BAND_NORMAL;
            end
        endcase
        tune = int'(trim_base);
        if (band_st == BAND_HOT)
            tune = tune - TRIM_DELTA;
        else if (band_st == BAND_COLD)
            tune = tune + TRIM_DELTA;
        if (tune < 0)
            tune = 0;
        if (tune > TUNE_MAX)
            tune = TUNE_MAX;
        r.temperature  = TEMP_OUT_W'(deg);
        r.band         = band_st;
        r.tuning_word  = TUNE_W'(tune);
        r.band_changed = (band_st != prev);
        if (r.band_changed)
            n_changes++;
        pending_trims.push_back(r);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push          <= 1'b1;
        sensor_sample <= s;
        do @(posedge clk); while (full);
        accumulate_sample(s);
        n_samples++;
    endtask

    task automatic send_group(input logic [SAMPLE_W-1:0] s);
        repeat (GROUP_LEN) send_sample(s);
    endtask

    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (pending_trims.size() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BASE_TUNING: trim_base      = data[TUNE_W-1:0];
            REG_HOT_ENTER:   thr_hot_enter  = data[THR_W-1:0];
            REG_HOT_EXIT:    thr_hot_exit   = data[THR_W-1:0];
            REG_COLD_ENTER:  thr_cold_enter = data[THR_W-1:0];
            REG_COLD_EXIT:   thr_cold_exit  = data[THR_W-1:0];
            REG_CAL_TEMP:    calib_temp     = data[TUNE_W-1:0];
            REG_CAL_ADC:     calib_adc      = data[SAMPLE_W-1:0];
            default:         ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Narrow registers get random upper bits, which the block must ignore.
    task automatic load_settings(input int base, input int he, input int hx, input int ce,
                                 input int cx, input int ct, input int ca);
        cfg_write(REG_BASE_TUNING, {4'($urandom), 8'(base)});
        cfg_write(REG_HOT_ENTER,   {4'($urandom), 8'(he)});
        cfg_write(REG_HOT_EXIT,    {4'($urandom), 8'(hx)});
        cfg_write(REG_COLD_ENTER,  {4'($urandom), 8'(ce)});
        cfg_write(REG_COLD_EXIT,   {4'($urandom), 8'(cx)});
        cfg_write(REG_CAL_TEMP,    {4'($urandom), 8'(ct)});
        cfg_write(REG_CAL_ADC,     12'(ca));
        cfg_write(REG_UNUSED,      12'($urandom));
    endtask

    task automatic test_reset_thresholds();
        send_group(adc_for_degrees(40));
        send_group(12'd0);
        send_group(adc_for_degrees(35));
        send_group(12'hFFF);
        send_group(adc_for_degrees(0));
    endtask

    task automatic test_both_entries();
        quiesce();
        load_settings(245, 10, 5, 20, 25, 25, 2048);
        send_group(adc_for_degrees(15));
        send_group(adc_for_degrees(25));
    endtask

    task automatic test_conversion_extremes();
        quiesce();
        load_settings(3, 127, -128, -128, 127, 255, 4095);
        send_group(12'd0);
        send_group(12'd0);
        quiesce();
        load_settings(255, 127, -128, -128, 127, 0, 0);
        send_group(12'hFFF);
    endtask

    task automatic test_random_walk();
        setting_kind_t kind;
        int n, c, ct, ca, lo, hi, delta, t_now, avg;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            quiesce();
            if (p == 2)
                kind = SET_FLOOR;
            else if (p == 5)
                kind = SET_CEILING;
            else if (p == 3 || p == 6)
                kind = SET_SCATTER;
            else
                kind = SET_CLUSTER;
            c = 0;
            ct = 0;
            ca = 0;
            case (kind)
                SET_FLOOR:   load_settings(0, -128, -128, -128, -128, 0, 0);
                SET_CEILING: load_settings(255, 127, 127, 127, 127, 255, 4095);
                SET_SCATTER:
                    load_settings($urandom_range(0, 255), int'($urandom_range(0, 255)) - 128,
                                  int'($urandom_range(0, 255)) - 128,
                                  int'($urandom_range(0, 255)) - 128,
                                  int'($urandom_range(0, 255)) - 128,
                                  $urandom_range(0, 255), $urandom_range(0, 4095));
                default:
                begin
                    c     = int'($urandom_range(0, 120)) - 60;
                    ct    = $urandom_range(0, 255);
                    delta = ((c - ct) * Q16_ONE) / GRAD_Q16;
                    lo    = (-delta > 500) ? -delta : 500;
                    hi    = (4095 - delta < 3500) ? 4095 - delta : 3500;
                    ca    = int'($urandom_range(lo, hi)) + delta;
                    lo    = c + int'($urandom_range(1, 20));
                    hi    = c - int'($urandom_range(1, 20));
                    load_settings($urandom_range(0, 255), lo, lo - int'($urandom_range(0, 10)),
                                  hi, hi + int'($urandom_range(0, 10)), ct, ca);
                end
            endcase
            n_settings++;
            tx_gap_max   = (p % 3 == 1) ? 0 : 4;
            rx_stall_max = (p % 4 == 2) ? 0 : 4;
            t_now = c;
            n = 200 + $urandom_range(0, 25);
            for (int i = 0; i < n; i++)
            begin
                if (i == n / 2 && p % 2 == 1)
                    drain_results();
                if (i % GROUP_LEN == 0)
                begin
                    t_now = t_now + int'($urandom_range(0, 8)) - 4;
                    if (t_now > c + 45)
                        t_now = c + 45;
                    if (t_now < c - 45)
                        t_now = c - 45;
                end
                if (kind != SET_CLUSTER || $urandom_range(0, 99) < 15)
                    avg = $urandom_range(0, 4095);
                else
                begin
                    avg = ca - ((t_now - ct) * Q16_ONE) / GRAD_Q16
                          + int'($urandom_range(0, 12)) - 6;
                    if (avg < 0)
                        avg = 0;
                    if (avg > 4095)
                        avg = 4095;
                end
                send_sample(SAMPLE_W'(avg));
            end
        end
    endtask

    initial
    begin : rx_proc
        int stall;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, rx_stall_max);
            repeat (stall)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            n_results++;
            if (pending_trims.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: trim result with none expected: temperature %0d band %0d",
                             $time, temperature, band);
                mismatches++;
            end
            else
            begin
                want = pending_trims.pop_front();
                if (temperature !== want.temperature || band !== want.band ||
                    tuning_word !== want.tuning_word || band_changed !== want.band_changed)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display({"%0t: expected temp %0d band %0d tune %0d chg %0b, ",
                                  "got %0d %0d %0d %0b"},
                                 $time, want.temperature, want.band, want.tuning_word,
                                 want.band_changed, temperature, band, tuning_word, band_changed);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        sensor_sample  = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        trim_base      = 8'd128;
        thr_hot_enter  = 8'sd40;
        thr_hot_exit   = 8'sd35;
        thr_cold_enter = 8'sd0;
        thr_cold_exit  = 8'sd5;
        calib_temp     = 8'd25;
        calib_adc      = 12'd2048;
        grp_sum        = 0;
        grp_cnt        = 0;
        band_st        = BAND_NORMAL;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_thresholds();
        test_both_entries();
        test_conversion_extremes();
        test_random_walk();

        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
        $display("Sent %0d samples, checked %0d trim results, %0d of them band changes.",
                 n_samples, n_results, n_changes);
        $display("Made %0d register writes over %0d random settings; %0d mismatches.",
                 n_writes, n_settings, mismatches);
        if (mismatches == 0 && pending_trims.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
